// ===== hw/rtl/umsc_pkg.sv =====
package umsc_pkg;

    typedef enum logic [1:0] {
        PH_CMD = 2'd0,
        PH_OUT = 2'd1,
        PH_IN  = 2'd2,
        PH_STS = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_HOST  = 2'd1,
        KIND_MRD   = 2'd2,
        KIND_MWR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_MAX_LUN  = 2'd0,
        CFG_ROM      = 2'd1,
        CFG_RAM      = 2'd2,
        CFG_WR_LUN   = 2'd3
    } cfg_idx_t;

    localparam logic [7:0] OP_TUR      = 8'h00;
    localparam logic [7:0] OP_REQSENSE = 8'h03;
    localparam logic [7:0] OP_INQUIRY  = 8'h12;
    localparam logic [7:0] OP_MODESNS  = 8'h1A;
    localparam logic [7:0] OP_STARTSTP = 8'h1B;
    localparam logic [7:0] OP_PREVENT  = 8'h1E;
    localparam logic [7:0] OP_RDFMTCAP = 8'h23;
    localparam logic [7:0] OP_RDCAP    = 8'h25;
    localparam logic [7:0] OP_READ10   = 8'h28;
    localparam logic [7:0] OP_WRITE10  = 8'h2A;

    localparam logic [31:0] CSW_SIG = 32'h53425355;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  host_byte;
        logic [3:0]  media_lun;
        logic [31:0] media_address;
        logic [7:0]  media_byte;
        logic        packet_end;
    } result_t;

    function automatic logic [7:0] std_inq(input logic [5:0] i);
        logic [7:0] r;
        begin
            unique case (i)
                6'd1: r = 8'h80;
                6'd2: r = 8'h04;
                6'd3: r = 8'h02;
                6'd4: r = 8'h1F;
                6'd8: r = 8'h43;
                6'd9: r = 8'h4F;
                6'd10: r = 8'h4B;
                6'd11: r = 8'h50;
                6'd16: r = 8'h4D;
                6'd17: r = 8'h53;
                6'd18: r = 8'h44;
                6'd32: r = 8'h30;
                6'd33: r = 8'h2E;
                6'd34: r = 8'h30;
                6'd35: r = 8'h31;
                default: r = (i >= 6'd12 && i <= 6'd31) ? 8'h20 : 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] vpd_inq(input logic [2:0] i);
        logic [7:0] r;
        begin
            unique case (i)
                3'd3: r = 8'h03;
                3'd5: r = 8'h80;
                3'd6: r = 8'h83;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] pos);
        logic [7:0] r;
        begin
            unique case (pos)
                2'd0: r = v[31:24];
                2'd1: r = v[23:16];
                2'd2: r = v[15:8];
                default: r = v[7:0];
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/umsc_gen.sv =====
// Generated reply bytes for the data-in phase of non-media commands.
module umsc_gen #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic [7:0]  opcode,
    input  logic        evpd,
    input  logic [31:0] idx,
    input  logic [7:0]  sense_key,
    input  logic [7:0]  sense_asc,
    input  logic [7:0]  sense_ascq,
    input  logic [3:0]  cmd_lun,
    input  logic [3:0]  writable_lun,
    input  logic [3:0]  eff_max,
    input  logic [31:0] rom_bytes,
    input  logic [31:0] ram_bytes,
    output logic [7:0]  gen_byte
);
    localparam int BSH = $clog2(BLOCK_BYTES);
    localparam logic [31:0] BB = 32'(BLOCK_BYTES);

    logic [31:0] rel;
    logic [28:0] desc;
    logic [2:0]  pos;
    logic [31:0] cap_sel;
    logic [31:0] cap_lun;

    always_comb
    begin
        rel  = idx - 32'd4;
        desc = rel[31:3];
        pos  = rel[2:0];
        cap_sel = (desc == {25'd0, writable_lun}) ? ram_bytes : rom_bytes;
        cap_lun = (cmd_lun == writable_lun) ? ram_bytes : rom_bytes;
        gen_byte = 8'h00;
        priority case (opcode)
            umsc_pkg::OP_INQUIRY:
                if (evpd)
                    gen_byte = (idx < 32'd7) ? umsc_pkg::vpd_inq(idx[2:0]) : 8'h00;
                else
                    gen_byte = (idx < 32'd36) ? umsc_pkg::std_inq(idx[5:0]) : 8'h00;
            umsc_pkg::OP_REQSENSE:
                if (idx == 32'd0) gen_byte = 8'h70;
                else if (idx == 32'd2) gen_byte = sense_key;
                else if (idx == 32'd7) gen_byte = 8'h0A;
                else if (idx == 32'd12) gen_byte = sense_asc;
                else if (idx == 32'd13) gen_byte = sense_ascq;
            umsc_pkg::OP_RDCAP:
                if (idx < 32'd4)
                    gen_byte = umsc_pkg::be_byte((cap_lun >> BSH) - 32'd1, idx[1:0]);
                else
                    gen_byte = umsc_pkg::be_byte(BB, idx[1:0]);
            umsc_pkg::OP_MODESNS:
                if (idx == 32'd0) gen_byte = 8'h03;
                else if (idx == 32'd2) gen_byte = (cmd_lun != writable_lun) ? 8'h80 : 8'h00;
            umsc_pkg::OP_RDFMTCAP:
                // list length 8 per unit; 16 units give 128
                if (idx == 32'd3) gen_byte = {1'b0, eff_max, 3'b000} + 8'd8;
                else if (idx > 32'd3) begin
                    if (!pos[2]) gen_byte = umsc_pkg::be_byte(cap_sel >> BSH, pos[1:0]);
                    else if (pos == 3'd4) gen_byte = 8'h00;
                    else gen_byte = umsc_pkg::be_byte(BB, pos[1:0]);
                end
            default: gen_byte = 8'h00;
        endcase
    end
endmodule

// ===== hw/rtl/usb_msc_bot_scsi_target_top.sv =====
// USB bulk-only mass storage device side with a small SCSI target.
// s_axis: one byte event per item. tuser = mode (0 host OUT byte, 1 IN slot),
//   tdata = OUT data byte.
// m_axis: exactly one result item per input item. tdata holds, from bit 0:
//   kind[1:0], host_byte[7:0], media_lun[3:0], media_address[31:0],
//   media_byte[7:0], then two zero bits; tlast = packet_end.
// cfg: write channel, cfg_index selects max_lun, rom_bytes, ram_bytes,
//   writable_lun (in that order); write only while idle. Always ready.
// Output: the result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled; the whole step is
//   one pass of logic from protocol state into the output register.
// Stall: while the output register holds an untaken result, a new item is
//   accepted only if the result is taken in the same cycle (s_tready =
//   !m_tvalid || m_tready).
// Reset: command phase, all decode state cleared, registers to defaults
//   (max_lun 15, rom 0, ram 29696, writable unit 1).
module usb_msc_bot_scsi_target_top #(
    parameter int BLOCK_BYTES  = 512,
    parameter int PACKET_BYTES = 64,
    parameter int LUN_COUNT    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // kind, host_byte, media_lun, media_address, media_byte
    output logic        m_axis_tlast,   // packet_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int BSH = $clog2(BLOCK_BYTES);
    localparam int PSH = $clog2(PACKET_BYTES);
    localparam logic [3:0] LUN_TOP = 4'(LUN_COUNT - 1);

    umsc_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  cbw_index_reg, cbw_index_next;
    logic [31:0] cmd_tag_reg, cmd_tag_next;
    logic [31:0] host_length_reg, host_length_next;
    logic [3:0]  cmd_lun_reg, cmd_lun_next;
    logic [7:0]  cdb_reg [16];
    logic [7:0]  cdb_next [16];
    logic [7:0]  sk_reg, sk_next, asc_reg, asc_next, ascq_reg, ascq_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic [31:0] xfer_len_reg, xfer_len_next;
    logic [31:0] start_block_reg, start_block_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] residue_reg, residue_next;
    logic [3:0]  max_lun_reg, wr_lun_reg;
    logic [31:0] rom_reg, ram_reg;
    umsc_pkg::result_t res_reg, res_next;
    logic        ovalid_reg;

    logic        take;
    logic [3:0]  eff_max;
    logic [7:0]  gbyte;
    logic [31:0] maddr;
    logic [31:0] bc_inc;
    logic [3:0]  csw_i;
    logic [7:0]  csw_b;
    logic [7:0]  op;
    logic [31:0] inq_n;

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign eff_max = (max_lun_reg < LUN_TOP) ? max_lun_reg : LUN_TOP;
    assign maddr = (start_block_reg << BSH) + byte_count_reg;
    assign bc_inc = byte_count_reg + 32'd1;
    assign op = cdb_reg[0];

    umsc_gen #(.BLOCK_BYTES(BLOCK_BYTES)) u_gen (
        .opcode(op), .evpd(cdb_reg[1][0]), .idx(byte_count_reg),
        .sense_key(sk_reg), .sense_asc(asc_reg), .sense_ascq(ascq_reg),
        .cmd_lun(cmd_lun_reg), .writable_lun(wr_lun_reg), .eff_max(eff_max),
        .rom_bytes(rom_reg), .ram_bytes(ram_reg), .gen_byte(gbyte)
    );

    // CSW byte index saturates at 12 (status byte)
    always_comb
    begin
        csw_i = (byte_count_reg < 32'd13) ? byte_count_reg[3:0] : 4'd12;
        if (csw_i < 4'd4) csw_b = umsc_pkg::CSW_SIG[8*csw_i[1:0] +: 8];
        else if (csw_i < 4'd8) csw_b = cmd_tag_reg[8*csw_i[1:0] +: 8];
        else if (csw_i < 4'd12) csw_b = residue_reg[8*csw_i[1:0] +: 8];
        else csw_b = {6'd0, status_reg};
    end

    always_comb
    begin
        logic [4:0]  i;
        logic [7:0]  nop;
        logic [3:0]  nlun;
        logic [31:0] nhl;
        logic        fail;
        logic [31:0] tl;
        logic [15:0] nblk;
        phase_next = phase_reg;
        cbw_index_next = cbw_index_reg;
        cmd_tag_next = cmd_tag_reg;
        host_length_next = host_length_reg;
        cmd_lun_next = cmd_lun_reg;
        cdb_next = cdb_reg;
        sk_next = sk_reg; asc_next = asc_reg; ascq_next = ascq_reg;
        byte_count_next = byte_count_reg;
        xfer_len_next = xfer_len_reg;
        start_block_next = start_block_reg;
        status_next = status_reg;
        residue_next = residue_reg;
        res_next = '0;
        i = cbw_index_reg;
        nop = 8'h00; nlun = 4'd0; nhl = 32'd0; fail = 1'b0; tl = 32'd0; nblk = 16'd0;
        inq_n = 32'd0;

        if (!s_axis_tuser && phase_reg == umsc_pkg::PH_CMD) begin
            if (i >= 5'd4 && i < 5'd8) cmd_tag_next[8*i[1:0] +: 8] = s_axis_tdata;
            else if (i >= 5'd8 && i < 5'd12) host_length_next[8*i[1:0] +: 8] = s_axis_tdata;
            else if (i == 5'd13) cmd_lun_next = s_axis_tdata[3:0];
            else if (i >= 5'd15) cdb_next[4'(i - 5'd15)] = s_axis_tdata;
            if (i >= 5'd30) begin
                // full CBW in hand: decode (cdb byte 15 is this byte)
                cbw_index_next = 5'd0;
                nop = cdb_next[0]; nlun = cmd_lun_next; nhl = host_length_next;
                status_next = 2'd0; residue_next = 32'd0;
                byte_count_next = 32'd0;
                inq_n = cdb_next[1][0] ? 32'd7 : 32'd36;
                if (nhl < inq_n) inq_n = nhl;
                nblk = {cdb_next[7], cdb_next[8]};
                if (nlun > eff_max) begin
                    fail = 1'b1; sk_next = 8'h05; asc_next = 8'h20; ascq_next = 8'h00;
                end else begin
                    priority case (nop)
                        umsc_pkg::OP_INQUIRY: begin
                            tl = inq_n; residue_next = nhl - inq_n;
                            sk_next = 8'h00; asc_next = 8'h00; ascq_next = 8'h00;
                        end
                        umsc_pkg::OP_TUR: begin
                            sk_next = 8'h00; asc_next = 8'h00; ascq_next = 8'h00;
                        end
                        umsc_pkg::OP_RDCAP: begin
                            tl = 32'd8;
                            sk_next = 8'h00; asc_next = 8'h00; ascq_next = 8'h00;
                        end
                        umsc_pkg::OP_REQSENSE: tl = 32'd18;
                        umsc_pkg::OP_MODESNS: begin
                            tl = 32'd4; residue_next = nhl - 32'd4;
                        end
                        umsc_pkg::OP_READ10, umsc_pkg::OP_WRITE10: begin
                            start_block_next = {cdb_next[2], cdb_next[3],
                                                cdb_next[4], cdb_next[5]};
                            if (nop == umsc_pkg::OP_WRITE10 && nlun != wr_lun_reg) begin
                                fail = 1'b1;
                                sk_next = 8'h07; asc_next = 8'h27; ascq_next = 8'h00;
                            end else begin
                                tl = {16'd0, nblk} << BSH;
                                sk_next = 8'h00; asc_next = 8'h00; ascq_next = 8'h00;
                            end
                        end
                        umsc_pkg::OP_RDFMTCAP: begin
                            tl = 32'd4 + ({28'd0, eff_max} + 32'd1) * 32'd8;
                            sk_next = 8'h00; asc_next = 8'h00; ascq_next = 8'h00;
                        end
                        umsc_pkg::OP_STARTSTP, umsc_pkg::OP_PREVENT: ;
                        default: begin
                            fail = 1'b1; sk_next = 8'h05; asc_next = 8'h20; ascq_next = 8'h00;
                        end
                    endcase
                end
                status_next = fail ? 2'd1 : 2'd0;
                xfer_len_next = tl;
                if (fail || tl == 32'd0) phase_next = umsc_pkg::PH_STS;
                else if (nop == umsc_pkg::OP_WRITE10) phase_next = umsc_pkg::PH_OUT;
                else phase_next = umsc_pkg::PH_IN;
            end else begin
                cbw_index_next = i + 5'd1;
            end
        end else if (!s_axis_tuser && phase_reg == umsc_pkg::PH_OUT) begin
            res_next.kind = umsc_pkg::KIND_MWR;
            res_next.media_lun = cmd_lun_reg;
            res_next.media_byte = s_axis_tdata;
            res_next.media_address = maddr;
            byte_count_next = bc_inc;
            if (bc_inc >= xfer_len_reg) begin
                phase_next = umsc_pkg::PH_STS; byte_count_next = 32'd0;
            end
        end else if (s_axis_tuser && phase_reg == umsc_pkg::PH_IN) begin
            if (op == umsc_pkg::OP_READ10) begin
                res_next.kind = umsc_pkg::KIND_MRD;
                res_next.media_lun = cmd_lun_reg;
                res_next.media_address = maddr;
            end else begin
                res_next.kind = umsc_pkg::KIND_HOST;
                res_next.host_byte = gbyte;
            end
            byte_count_next = bc_inc;
            res_next.packet_end = (bc_inc[PSH-1:0] == '0) || (bc_inc >= xfer_len_reg);
            if (bc_inc >= xfer_len_reg) begin
                phase_next = umsc_pkg::PH_STS; byte_count_next = 32'd0;
            end
        end else if (s_axis_tuser && phase_reg == umsc_pkg::PH_STS) begin
            res_next.kind = umsc_pkg::KIND_HOST;
            res_next.host_byte = csw_b;
            res_next.packet_end = ((32'(csw_i) + 32'd1) % PACKET_BYTES == 0)
                                  || (csw_i == 4'd12);
            if (csw_i >= 4'd12) begin
                phase_next = umsc_pkg::PH_CMD; byte_count_next = 32'd0;
                cbw_index_next = 5'd0;
            end else begin
                byte_count_next = 32'(csw_i) + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= umsc_pkg::PH_CMD;
            cbw_index_reg <= '0;
            cmd_tag_reg <= '0;
            host_length_reg <= '0;
            cmd_lun_reg <= '0;
            for (int k = 0; k < 16; k++) cdb_reg[k] <= '0;
            sk_reg <= '0; asc_reg <= '0; ascq_reg <= '0;
            byte_count_reg <= '0;
            xfer_len_reg <= '0;
            start_block_reg <= '0;
            status_reg <= '0;
            residue_reg <= '0;
            ovalid_reg <= 1'b0;
            max_lun_reg <= 4'd15;
            rom_reg <= 32'd0;
            ram_reg <= 32'd29696;
            wr_lun_reg <= 4'd1;
        end else begin
            if (take) begin
                phase_reg <= phase_next;
                cbw_index_reg <= cbw_index_next;
                cmd_tag_reg <= cmd_tag_next;
                host_length_reg <= host_length_next;
                cmd_lun_reg <= cmd_lun_next;
                cdb_reg <= cdb_next;
                sk_reg <= sk_next; asc_reg <= asc_next; ascq_reg <= ascq_next;
                byte_count_reg <= byte_count_next;
                xfer_len_reg <= xfer_len_next;
                start_block_reg <= start_block_next;
                status_reg <= status_next;
                residue_reg <= residue_next;
                ovalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (umsc_pkg::cfg_idx_t'(cfg_index))
                    umsc_pkg::CFG_MAX_LUN: max_lun_reg <= cfg_data[3:0];
                    umsc_pkg::CFG_ROM:     rom_reg <= cfg_data;
                    umsc_pkg::CFG_RAM:     ram_reg <= cfg_data;
                    umsc_pkg::CFG_WR_LUN:  wr_lun_reg <= cfg_data[3:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) res_reg <= res_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {2'b00, res_reg.media_byte, res_reg.media_address,
                           res_reg.media_lun, res_reg.host_byte, res_reg.kind};
    assign m_axis_tlast = res_reg.packet_end;

endmodule
